/* rtl/ptss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types and codes of the periodic task slice scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

   localparam int MAX_TASKS_DEF   = 16;
   localparam int PERIOD_BITS_DEF = 16;
   localparam int ID_BITS         = 4;
   localparam int PERIOD_IN_BITS  = 16;
   localparam int SLICE_BITS      = 16;
   localparam int COUNT_OUT_BITS  = 5;

   // Command kinds
   localparam logic [2:0] KIND_TICK     = 3'd0;
   localparam logic [2:0] KIND_DISPATCH = 3'd1;
   localparam logic [2:0] KIND_ADD      = 3'd2;
   localparam logic [2:0] KIND_REMOVE   = 3'd3;
   localparam logic [2:0] KIND_QUERY    = 3'd4;

   // Status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [1:0] STAT_DUP      = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0]                kind;
      logic [ID_BITS-1:0]        task_id;
      logic [PERIOD_IN_BITS-1:0] period;
   } req_type;

   typedef struct packed {
      logic                      dispatched;
      logic [ID_BITS-1:0]        run_id;
      logic                      last;
      logic [1:0]                status;
      logic                      exists;
      logic [SLICE_BITS-1:0]     slice_len;
      logic [COUNT_OUT_BITS-1:0] task_count;
   } rsp_type;

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_WALK = 3'b010,
      FSM_FIN  = 3'b100
   } fsm_type;

endpackage

/* rtl/ptss_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptss_table
// Task table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptss_table #(
   parameter int DEPTH     = 16,
   parameter int WIDTH     = 37,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/periodic_task_slice_scheduler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_slice_scheduler_core
// Ordered table of periodic tasks with tick, dispatch, add, remove and query.
// ----------------------------------------------------------------------------
// Usage: raise start with a command in req_data; the command is taken at the
// edge where start is high and busy is low. Every command walks the task
// table held in one synchronous memory, one entry per cycle, and busy stays
// high from acceptance until the final result of the command appears.
// Results come out on rsp_data, each for exactly one cycle under rsp_strobe,
// and cannot be held off: capture them when they appear. Tick, add, remove,
// query and an empty dispatch give a single result with last set; a dispatch
// gives one result per pending task in insertion order, the final one with
// last set. Results of one command leave before the next command's results.
// ----------------------------------------------------------------------------
module periodic_task_slice_scheduler_core #(
   parameter int MAX_TASKS   = ptss_pkg::MAX_TASKS_DEF,
   parameter int PERIOD_BITS = ptss_pkg::PERIOD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptss_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ptss_pkg::rsp_type rsp_data
);

   import ptss_pkg::*;

   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int PB = PERIOD_BITS;
   // Entry layout: {id, period, countdown, pending}
   localparam int EW = ID_BITS + 2 * PB + 1;

   // Control state
   fsm_type         state_ff, state_in;
   req_type         cmd_ff, cmd_in;
   logic [CW-1:0]   total_ff, total_in;
   logic [CW-1:0]   rd_idx_ff, rd_idx_in;
   logic            rd_vld_ff, rd_vld_in;
   logic [AW-1:0]   proc_idx_ff, proc_idx_in;
   logic            found_ff, found_in;
   logic [PB-1:0]   found_per_ff, found_per_in;
   logic            held_vld_ff, held_vld_in;
   logic [ID_BITS-1:0] held_id_ff, held_id_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   rsp_type         rsp_ff, rsp_in;

   // Table ports
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [EW-1:0]   wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [EW-1:0]   rd_data;

   // Fields of the entry under processing
   logic [ID_BITS-1:0] e_id;
   logic [PB-1:0]      e_per;
   logic [PB-1:0]      e_cd;
   logic               e_pend;
   logic [PB-1:0]      cd_dec;
   logic [PB-1:0]      req_per;
   logic [PB-1:0]      add_per;

   assign e_id   = rd_data[EW-1 -: ID_BITS];
   assign e_per  = rd_data[2*PB:PB+1];
   assign e_cd   = rd_data[PB:1];
   assign e_pend = rd_data[0];
   assign cd_dec = e_cd - PB'(1);

   // Keep the low PERIOD_BITS bits of the period, widen if the table is wider
   assign req_per = PB'(req_data.period);
   assign add_per = PB'(cmd_ff.period);

   ptss_table #(
      .DEPTH     (MAX_TASKS),
      .WIDTH     (EW),
      .ADDR_BITS (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Issue a read per cycle while the walk has entries left
   assign rd_en   = (state_ff == FSM_WALK) && (rd_idx_ff < total_ff);
   assign rd_addr = rd_idx_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      total_in      = total_ff;
      rd_idx_in     = rd_idx_ff;
      rd_vld_in     = 1'b0;
      proc_idx_in   = proc_idx_ff;
      found_in      = found_ff;
      found_per_in  = found_per_ff;
      held_vld_in   = held_vld_ff;
      held_id_in    = held_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = proc_idx_ff;
      wr_data       = rd_data;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               cmd_in      = req_data;
               cmd_in.period = PERIOD_IN_BITS'(req_per);
               rd_idx_in   = '0;
               found_in    = 1'b0;
               held_vld_in = 1'b0;
               state_in    = FSM_WALK;
            end
         end

         FSM_WALK: begin
            // Read side: advance through the table
            if (rd_en) begin
               rd_idx_in   = rd_idx_ff + CW'(1);
               rd_vld_in   = 1'b1;
               proc_idx_in = rd_addr;
            end else begin
               state_in = FSM_FIN;
            end

            // Process side: the entry read in the previous cycle
            if (rd_vld_ff) begin
               case (cmd_ff.kind)
                  KIND_TICK: begin
                     if (e_cd != '0) begin
                        wr_en = 1'b1;
                        if (cd_dec == '0) begin
                           wr_data = {e_id, e_per, e_per, 1'b1};
                        end else begin
                           wr_data = {e_id, e_per, cd_dec, e_pend};
                        end
                     end
                  end
                  KIND_DISPATCH: begin
                     if (e_pend) begin
                        wr_en   = 1'b1;
                        wr_data = {e_id, e_per, e_cd, 1'b0};
                        // Hold the newest id back until we know if it is the last
                        if (held_vld_ff) begin
                           rsp_strobe_in     = 1'b1;
                           rsp_in            = '0;
                           rsp_in.dispatched = 1'b1;
                           rsp_in.run_id     = held_id_ff;
                           rsp_in.task_count = COUNT_OUT_BITS'(total_ff);
                        end
                        held_vld_in = 1'b1;
                        held_id_in  = e_id;
                     end
                  end
                  KIND_ADD, KIND_REMOVE, KIND_QUERY: begin
                     if (!found_ff && (e_id == cmd_ff.task_id)) begin
                        found_in     = 1'b1;
                        found_per_in = e_per;
                     end else if (found_ff && (cmd_ff.kind == KIND_REMOVE)) begin
                        // Close the gap: move each later entry down by one
                        wr_en   = 1'b1;
                        wr_addr = proc_idx_ff - AW'(1);
                        wr_data = rd_data;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         FSM_FIN: begin
            state_in          = FSM_IDLE;
            rsp_strobe_in     = 1'b1;
            rsp_in            = '0;
            rsp_in.last       = 1'b1;
            rsp_in.status     = STAT_OK;
            rsp_in.task_count = COUNT_OUT_BITS'(total_ff);
            case (cmd_ff.kind)
               KIND_DISPATCH: begin
                  if (held_vld_ff) begin
                     rsp_in.dispatched = 1'b1;
                     rsp_in.run_id     = held_id_ff;
                  end
               end
               KIND_ADD: begin
                  rsp_in.run_id = cmd_ff.task_id;
                  if (found_ff) begin
                     rsp_in.status = STAT_DUP;
                  end else if (total_ff >= CW'(MAX_TASKS)) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     wr_en             = 1'b1;
                     wr_addr           = total_ff[AW-1:0];
                     wr_data           = {cmd_ff.task_id, add_per, add_per, 1'b0};
                     total_in          = total_ff + CW'(1);
                     rsp_in.task_count = COUNT_OUT_BITS'(total_in);
                  end
               end
               KIND_REMOVE: begin
                  rsp_in.run_id = cmd_ff.task_id;
                  if (found_ff) begin
                     total_in          = total_ff - CW'(1);
                     rsp_in.task_count = COUNT_OUT_BITS'(total_in);
                  end else begin
                     rsp_in.status = STAT_NOTFOUND;
                  end
               end
               KIND_QUERY: begin
                  rsp_in.run_id = cmd_ff.task_id;
                  if (found_ff) begin
                     rsp_in.exists    = 1'b1;
                     rsp_in.slice_len = SLICE_BITS'(found_per_ff);
                  end else begin
                     rsp_in.status = STAT_NOTFOUND;
                  end
               end
               default: begin
                  // Tick and unknown kinds: plain acknowledgement
               end
            endcase
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         total_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         held_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         rd_vld_ff     <= rd_vld_in;
         found_ff      <= found_in;
         held_vld_ff   <= held_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      rd_idx_ff    <= rd_idx_in;
      proc_idx_ff  <= proc_idx_in;
      found_per_ff <= found_per_in;
      held_id_ff   <= held_id_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // Walk never writes back the entry it is reading in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("table read and write hit the same entry");

   // The table never holds more tasks than it has room for
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(MAX_TASKS))
      else $error("task count beyond table depth");

   // An accepted command keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // A dispatched result carries no query or error information
   a_dispatch_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.dispatched) |->
         ((rsp_data.status == STAT_OK) && !rsp_data.exists))
      else $error("dispatched result with status or query fields set");
`endif

endmodule
